### rtl/kmd_pkg.sv
package kmd_pkg;

  // matrix geometry
  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int KEY_COUNT = MAX_ROWS * MAX_COLS;
  localparam int KEY_W     = $clog2(KEY_COUNT);

  // field widths
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int DIM_W      = 4;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int NOTE_W     = 7;
  localparam int CHAN_W     = 5;
  localparam int IDXF_W     = ROW_W + DIM_W + 2;
  localparam int NOTE_SUM_W = IDXF_W + 1;

  localparam int NOTE_TOP = 127;
  localparam logic [NOTE_W-1:0] VEL_ON  = 7'd127;
  localparam logic [NOTE_W-1:0] VEL_OFF = 7'd0;

  // queues between the parts
  localparam int MID_DEPTH = 2;
  localparam int MID_PTR_W = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int EVT_DEPTH = 4;
  localparam int EVT_PTR_W = $clog2(EVT_DEPTH);
  localparam int EVT_CNT_W = $clog2(EVT_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS  = 3'd0,
    CFG_NUM_COLS  = 3'd1,
    CFG_DEBOUNCE  = 3'd2,
    CFG_BASE_NOTE = 3'd3,
    CFG_CHANNEL   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  num_rows;
    logic [DIM_W-1:0]  num_cols;
    logic [DEB_W-1:0]  debounce_ms;
    logic [NOTE_W-1:0] base_note;
    logic [CHAN_W-1:0] midi_channel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    num_rows:     4'd8,
    num_cols:     4'd8,
    debounce_ms:  16'd50,
    base_note:    7'd36,
    midi_channel: 5'd1
  };

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic              note_on;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] velocity;
    logic [CHAN_W-1:0] channel;
  } out_word_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [KEY_W-1:0]  idx;
    logic              level;
    logic [TIME_W-1:0] now_ms;
    logic [NOTE_W-1:0] note;
    logic              note_ok;
  } mid_word_t;

  // per-key debounce state
  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] stamp;
  } key_state_t;

endpackage

### rtl/kmd_ram.sv
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/kmd_front.sv
module kmd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  kmd_pkg::cfg_t       cfg,
  input  logic                in_push,
  output logic                in_full,
  input  kmd_pkg::in_word_t   in_data,
  output logic                mid_vld,
  output kmd_pkg::mid_word_t  mid_data,
  input  logic                mid_pop
);

  logic [kmd_pkg::DIM_W-1:0]      rows;
  logic [kmd_pkg::DIM_W-1:0]      cols;
  logic [kmd_pkg::IDXF_W-1:0]     idx_full;
  logic [kmd_pkg::NOTE_SUM_W-1:0] note_sum;
  logic                           in_range;
  logic                           accept;
  logic                           q_push;
  logic                           q_pop;
  kmd_pkg::mid_word_t             word;

  kmd_pkg::mid_word_t             q_r [kmd_pkg::MID_DEPTH];
  logic [kmd_pkg::MID_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kmd_pkg::MID_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kmd_pkg::MID_CNT_W-1:0]  cnt_r, cnt_nxt;

  // clamp the configured matrix to the built size
  assign rows = (cfg.num_rows > kmd_pkg::DIM_W'(kmd_pkg::MAX_ROWS))
              ? kmd_pkg::DIM_W'(kmd_pkg::MAX_ROWS) : cfg.num_rows;
  assign cols = (cfg.num_cols > kmd_pkg::DIM_W'(kmd_pkg::MAX_COLS))
              ? kmd_pkg::DIM_W'(kmd_pkg::MAX_COLS) : cfg.num_cols;

  // key index and note number
  assign idx_full = kmd_pkg::IDXF_W'(in_data.row) * kmd_pkg::IDXF_W'(cols)
                  + kmd_pkg::IDXF_W'(in_data.col);
  assign note_sum = kmd_pkg::NOTE_SUM_W'(cfg.base_note)
                  + kmd_pkg::NOTE_SUM_W'(idx_full);

  assign in_range = (kmd_pkg::DIM_W'(in_data.row) < rows)
                 && (kmd_pkg::DIM_W'(in_data.col) < cols)
                 && (idx_full < kmd_pkg::IDXF_W'(kmd_pkg::KEY_COUNT));

  always_comb begin
    word.idx     = idx_full[kmd_pkg::KEY_W-1:0];
    word.level   = in_data.pressed;
    word.now_ms  = in_data.now_ms;
    word.note    = note_sum[kmd_pkg::NOTE_W-1:0];
    word.note_ok = (note_sum <= kmd_pkg::NOTE_SUM_W'(kmd_pkg::NOTE_TOP));
  end

  // out-of-matrix samples are dropped here
  assign in_full = (cnt_r == kmd_pkg::MID_CNT_W'(kmd_pkg::MID_DEPTH));
  assign accept  = in_push && !in_full;
  assign q_push  = accept && in_range;
  assign mid_vld = (cnt_r != '0);
  assign q_pop   = mid_pop && mid_vld;
  assign mid_data = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == kmd_pkg::MID_PTR_W'(kmd_pkg::MID_DEPTH - 1))
                 ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == kmd_pkg::MID_PTR_W'(kmd_pkg::MID_DEPTH - 1))
                 ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + kmd_pkg::MID_CNT_W'(q_push) - kmd_pkg::MID_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wr_ptr_r] <= word;
    end
  end

endmodule

### rtl/kmd_back.sv
module kmd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kmd_pkg::cfg_t                  cfg,
  input  logic                           mid_vld,
  input  kmd_pkg::mid_word_t             mid_data,
  output logic                           mid_pop,
  input  logic [kmd_pkg::EVT_CNT_W-1:0]  evt_cnt,
  output logic                           evt_push,
  output kmd_pkg::out_word_t             evt_data
);

  logic [kmd_pkg::EVT_CNT_W:0]    inflight;
  logic                           room;
  logic                           s1_vld_r;
  kmd_pkg::mid_word_t             s1_r;
  kmd_pkg::key_state_t            ram_rdata;
  kmd_pkg::key_state_t            cur;
  kmd_pkg::key_state_t            wr_state;
  logic [kmd_pkg::TIME_W-1:0]     elapsed;
  logic                           change;
  logic [kmd_pkg::KEY_COUNT-1:0]  key_vld_r;
  logic                           byp_vld_r;
  logic [kmd_pkg::KEY_W-1:0]      byp_idx_r;
  kmd_pkg::key_state_t            byp_r;

  // take a word only if its result is sure to find a queue slot
  assign inflight = (kmd_pkg::EVT_CNT_W + 1)'(evt_cnt)
                  + (kmd_pkg::EVT_CNT_W + 1)'(s1_vld_r);
  assign room     = inflight < (kmd_pkg::EVT_CNT_W + 1)'(kmd_pkg::EVT_DEPTH);
  assign mid_pop  = mid_vld && room;

  kmd_ram #(
    .WIDTH ($bits(kmd_pkg::key_state_t)),
    .DEPTH (kmd_pkg::KEY_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (change),
    .waddr (s1_r.idx),
    .wdata (wr_state),
    .re    (mid_pop),
    .raddr (mid_data.idx),
    .rdata (ram_rdata)
  );

  // lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_r <= mid_data;
    end
  end

  // newest write wins, then the ram, then the reset value
  always_comb begin
    if (byp_vld_r && (byp_idx_r == s1_r.idx)) begin
      cur = byp_r;
    end else if (key_vld_r[s1_r.idx]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
  end

  // debounce decision
  assign elapsed = s1_r.now_ms - cur.stamp;
  assign change  = s1_vld_r && (s1_r.level != cur.level)
                && (elapsed > kmd_pkg::TIME_W'(cfg.debounce_ms));

  always_comb begin
    wr_state.level = s1_r.level;
    wr_state.stamp = s1_r.now_ms;
  end

  // per-key written flags and last-write bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= '0;
      byp_vld_r <= 1'b0;
    end else if (change) begin
      key_vld_r[s1_r.idx] <= 1'b1;
      byp_vld_r           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (change) begin
      byp_idx_r <= s1_r.idx;
      byp_r     <= wr_state;
    end
  end

  // note event
  assign evt_push = change && s1_r.note_ok;

  always_comb begin
    evt_data.note_on  = s1_r.level;
    evt_data.note     = s1_r.note;
    evt_data.velocity = s1_r.level ? kmd_pkg::VEL_ON : kmd_pkg::VEL_OFF;
    evt_data.channel  = cfg.midi_channel;
  end

  // a key's state is marked written the cycle after its update
  a_vld_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    change |=> key_vld_r[$past(s1_r.idx)])
    else $error("key state written but not marked valid");

  // the lookup stage only holds a word popped in the cycle before
  a_s1_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(mid_pop))
    else $error("lookup stage valid without a pop");

  // the event queue never overflows
  a_evt_room: assert property (@(posedge clk) disable iff (!rst_n)
    evt_push |-> (evt_cnt < kmd_pkg::EVT_CNT_W'(kmd_pkg::EVT_DEPTH)))
    else $error("event pushed into a full queue");

endmodule

### rtl/kmd_evt_q.sv
module kmd_evt_q (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  kmd_pkg::out_word_t             push_data,
  input  logic                           pop,
  output logic                           empty,
  output kmd_pkg::out_word_t             head,
  output logic [kmd_pkg::EVT_CNT_W-1:0]  cnt
);

  kmd_pkg::out_word_t             q_r [kmd_pkg::EVT_DEPTH];
  logic [kmd_pkg::EVT_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kmd_pkg::EVT_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kmd_pkg::EVT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           pop_ok;

  assign empty  = (cnt_r == '0);
  assign pop_ok = pop && !empty;
  assign head   = q_r[rd_ptr_r];
  assign cnt    = cnt_r;

  // ring pointers, depth is a power of two
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + kmd_pkg::EVT_PTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + kmd_pkg::EVT_PTR_W'(pop_ok);
    cnt_nxt    = cnt_r + kmd_pkg::EVT_CNT_W'(push) - kmd_pkg::EVT_CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/key_matrix_debounce_to_notes.sv
// Key matrix debounce to note events.
// Input queue side: drive in_data with one key sample (row, col, pressed,
// now_ms) and raise in_push; the word is taken on a clock edge where
// in_full is low. Samples outside the configured matrix are dropped.
// Output queue side: while out_empty is low, out_data holds the oldest
// note event; raise out_pop to take it. Samples that pass the debounce
// test and map to a note in range produce one event, others none.
// A sample is registered in the front queue, lookup stage and event queue.
// Throughput: one sample per cycle unless stalled, set by the single read
// and single write port of the per-key state memory, with a bypass of the
// last write so back-to-back samples of the same key see fresh state. If
// out_pop stays low the four-entry event queue fills, the back end stops
// drawing from the two-entry front queue, and in_full then rises.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx; write only
// while idle. Reset (rst_n low, synchronous) empties both queues, restores
// the register defaults and marks every key released with time zero; no
// clearing sweep is needed, samples are taken once reset is released.
module key_matrix_debounce_to_notes (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  kmd_pkg::in_word_t               in_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output kmd_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  kmd_pkg::cfg_t                  cfg_r, cfg_nxt;
  logic                           mid_vld;
  kmd_pkg::mid_word_t             mid_data;
  logic                           mid_pop;
  logic [kmd_pkg::EVT_CNT_W-1:0]  evt_cnt;
  logic                           evt_push;
  kmd_pkg::out_word_t             evt_data;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (kmd_pkg::cfg_idx_t'(cfg_idx))
        kmd_pkg::CFG_NUM_ROWS:  cfg_nxt.num_rows     = cfg_wdata[kmd_pkg::DIM_W-1:0];
        kmd_pkg::CFG_NUM_COLS:  cfg_nxt.num_cols     = cfg_wdata[kmd_pkg::DIM_W-1:0];
        kmd_pkg::CFG_DEBOUNCE:  cfg_nxt.debounce_ms  = cfg_wdata[kmd_pkg::DEB_W-1:0];
        kmd_pkg::CFG_BASE_NOTE: cfg_nxt.base_note    = cfg_wdata[kmd_pkg::NOTE_W-1:0];
        kmd_pkg::CFG_CHANNEL:   cfg_nxt.midi_channel = cfg_wdata[kmd_pkg::CHAN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= kmd_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify and queue samples
  kmd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .mid_vld  (mid_vld),
    .mid_data (mid_data),
    .mid_pop  (mid_pop)
  );

  // debounce against per-key state
  kmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .mid_vld  (mid_vld),
    .mid_data (mid_data),
    .mid_pop  (mid_pop),
    .evt_cnt  (evt_cnt),
    .evt_push (evt_push),
    .evt_data (evt_data)
  );

  // note event queue
  kmd_evt_q u_evt_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (evt_data),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_data),
    .cnt       (evt_cnt)
  );

endmodule

### bench/tb_key_matrix_debounce_to_notes.sv
module tb_key_matrix_debounce_to_notes;
  timeunit 1ns;
  timeprecision 1ps;

  import kmd_pkg::*;

  localparam int DRAIN_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  // DUT connections
  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_word_t              in_data;
  logic                  out_empty;
  logic                  out_pop;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  key_matrix_debounce_to_notes DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the register file and the per-key debounce state
  cfg_t        cur_cfg;
  bit          key_down [KEY_COUNT];
  bit [31:0]   key_stamp[KEY_COUNT];

  in_word_t    samples_pending[$];
  out_word_t   note_events_due[$];
  int          n_sent;
  int          n_taken;
  int          n_errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit [31:0]   ms_clock;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // expected note event for one sample, updates the shadow key state
  function automatic void predict_note_event(in_word_t s);
    int        rows;
    int        cols;
    int        idx;
    int        note_sum;
    bit [31:0] elapsed;
    out_word_t ev;
    rows = (cur_cfg.num_rows > MAX_ROWS) ? MAX_ROWS : int'(cur_cfg.num_rows);
    cols = (cur_cfg.num_cols > MAX_COLS) ? MAX_COLS : int'(cur_cfg.num_cols);
    if (int'(s.row) >= rows || int'(s.col) >= cols) return;
    idx = int'(s.row) * cols + int'(s.col);
    if (s.pressed == key_down[idx]) return;
    elapsed = s.now_ms - key_stamp[idx];
    if (elapsed <= 32'(cur_cfg.debounce_ms)) return;
    key_down[idx]  = s.pressed;
    key_stamp[idx] = s.now_ms;
    note_sum = int'(cur_cfg.base_note) + idx;
    // state moved, but the note is off the top of the range
    if (note_sum > NOTE_TOP) return;
    ev.note_on  = s.pressed;
    ev.note     = NOTE_W'(note_sum);
    ev.velocity = s.pressed ? VEL_ON : VEL_OFF;
    ev.channel  = cur_cfg.midi_channel;
    note_events_due.push_back(ev);
  endfunction

  // input driver: next word at the falling edge, hold until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && n_taken != n_sent) begin
      // word still waiting on in_full
    end else if (samples_pending.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_data <= samples_pending.pop_front();
      in_push <= 1'b1;
      n_sent++;
    end else begin
      in_push <= 1'b0;
    end
  end

  // result side pop pattern
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: predict on accepted samples, check popped events
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        n_taken++;
        predict_note_event(in_data);
      end
      if (out_pop && !out_empty) begin
        if (note_events_due.size() == 0) begin
          report_mismatch($sformatf("unexpected event note %0d on %0b",
                                    out_data.note, out_data.note_on));
        end else begin
          want = note_events_due.pop_front();
          if (out_data.note_on !== want.note_on)
            report_mismatch($sformatf("note %0d: note_on %b, want %b",
                                      want.note, out_data.note_on, want.note_on));
          if (out_data.note !== want.note)
            report_mismatch($sformatf("note %0d, want %0d", out_data.note, want.note));
          if (out_data.velocity !== want.velocity)
            report_mismatch($sformatf("note %0d: velocity %0d, want %0d",
                                      want.note, out_data.velocity, want.velocity));
          if (out_data.channel !== want.channel)
            report_mismatch($sformatf("note %0d: channel %0d, want %0d",
                                      want.note, out_data.channel, want.channel));
        end
      end
    end
  end

  task automatic add_sample(int r, int c, bit lvl, bit [31:0] stamp);
    in_word_t w;
    w.row     = ROW_W'(r);
    w.col     = COL_W'(c);
    w.pressed = lvl;
    w.now_ms  = stamp;
    samples_pending.push_back(w);
  endtask

  // one register write per cycle, cfg_we stays high across a sequence
  task automatic write_cfg(cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    case (idx)
      CFG_NUM_ROWS:  cur_cfg.num_rows     = DIM_W'(value);
      CFG_NUM_COLS:  cur_cfg.num_cols     = DIM_W'(value);
      CFG_DEBOUNCE:  cur_cfg.debounce_ms  = DEB_W'(value);
      CFG_BASE_NOTE: cur_cfg.base_note    = NOTE_W'(value);
      CFG_CHANNEL:   cur_cfg.midi_channel = CHAN_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setting(int rows, int cols, int deb, int base, int chan);
    write_cfg(CFG_NUM_ROWS, rows);
    write_cfg(CFG_NUM_COLS, cols);
    write_cfg(CFG_DEBOUNCE, deb);
    write_cfg(CFG_BASE_NOTE, base);
    write_cfg(CFG_CHANNEL, chan);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for all words taken and all events seen, then let the pipe empty
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    while ((samples_pending.size() != 0 || n_sent != n_taken ||
            note_events_due.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      report_mismatch($sformatf("%0d samples and %0d events still outstanding",
                                samples_pending.size(), note_events_due.size()));
      note_events_due.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly bounce bursts that settle, plus single samples and noise
  task automatic gen_random_samples(int count);
    int n;
    int kind;
    int rows;
    int cols;
    int r;
    int c;
    int len;
    int deb;
    bit lvl;
    n    = 0;
    deb  = int'(cur_cfg.debounce_ms);
    rows = (cur_cfg.num_rows > MAX_ROWS) ? MAX_ROWS : int'(cur_cfg.num_rows);
    cols = (cur_cfg.num_cols > MAX_COLS) ? MAX_COLS : int'(cur_cfg.num_cols);
    while (n < count) begin
      kind = $urandom_range(0, 99);
      if (rows == 0 || cols == 0) begin
        r = $urandom_range(0, 7);
        c = $urandom_range(0, 7);
      end else begin
        r = $urandom_range(0, rows - 1);
        c = $urandom_range(0, cols - 1);
      end
      lvl = $urandom_range(0, 1);
      if (kind < 55) begin
        // contact bounce, then a stable level past the quiet time
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) begin
          ms_clock = ms_clock + 32'($urandom_range(0, deb / 4 + 1));
          add_sample(r, c, lvl ^ bit'(j % 2), ms_clock);
        end
        ms_clock = ms_clock + 32'(deb + $urandom_range(1, deb / 2 + 2));
        add_sample(r, c, lvl, ms_clock);
        n += len + 1;
      end else if (kind < 85) begin
        ms_clock = ms_clock + 32'($urandom_range(0, deb / 8 + 2));
        add_sample(r, c, lvl, ms_clock);
        n++;
      end else if (kind < 95) begin
        // anywhere in the full 8x8 space, often outside the matrix
        ms_clock = ms_clock + 32'($urandom_range(0, deb / 8 + 2));
        add_sample($urandom_range(0, 7), $urandom_range(0, 7), lvl, ms_clock);
        n++;
      end else if (kind < 98) begin
        // move the time base close to the 32-bit wrap
        ms_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 4 * deb + 8));
      end else begin
        add_sample(r, c, lvl, $urandom);
        n++;
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_data       = '0;
    out_pop       = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    n_sent        = 0;
    n_taken       = 0;
    n_errors      = 0;
    send_idle_pct = 31;
    recv_idle_pct = 65;
    cur_cfg       = CFG_RESET;
    ms_clock      = $urandom;
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_down[k]  = 1'b0;
      key_stamp[k] = '0;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: early changes, debounce edge, wrap of the time stamp
    add_sample(0, 0, 1'b1, 32'd10);
    add_sample(0, 0, 1'b1, 32'd50);
    add_sample(0, 0, 1'b1, 32'd51);
    add_sample(0, 0, 1'b1, 32'd55);
    add_sample(0, 0, 1'b0, 32'd60);
    add_sample(0, 0, 1'b0, 32'd200);
    add_sample(0, 1, 1'b0, 32'd300);
    add_sample(7, 7, 1'b1, 32'hFFFF_FFFF);
    add_sample(7, 7, 1'b0, 32'h0000_0030);
    add_sample(7, 7, 1'b0, 32'h0000_0031);
    add_sample(7, 7, 1'b0, 32'h0000_0032);
    add_sample(7, 0, 1'b1, 32'd1000);
    add_sample(3, 5, 1'b1, 32'h8000_0000);
    add_sample(3, 5, 1'b0, 32'hFFFF_0000);
    drain_and_settle();

    // small matrix, no debounce, note at the top, channel zero
    apply_setting(2, 3, 0, 127, 0);
    add_sample(2, 0, 1'b1, 32'd5000);
    add_sample(0, 3, 1'b1, 32'd5000);
    add_sample(0, 0, 1'b1, 32'd5000);
    add_sample(0, 1, 1'b1, 32'd5001);
    add_sample(0, 1, 1'b0, 32'd5002);
    add_sample(0, 0, 1'b0, 32'd5000);
    add_sample(0, 0, 1'b0, 32'd5001);
    drain_and_settle();

    // random phases over a range of settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      if (p < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 65;
      end else if (p < 5) begin
        send_idle_pct = 65;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: begin
          apply_setting(15, 15, 200, 100, 31);
          gen_random_samples(280);
        end
        1: begin
          apply_setting(1, 1, 65535, 0, 16);
          gen_random_samples(120);
        end
        2: begin
          apply_setting(0, 5, 10, 0, 17);
          gen_random_samples(40);
        end
        3: begin
          apply_setting(5, 0, 10, 5, 3);
          gen_random_samples(40);
        end
        4: begin
          apply_setting(3, 7, 5, 20, 9);
          gen_random_samples(300);
        end
        5: begin
          apply_setting(8, 8, 0, 0, 2);
          gen_random_samples(330);
        end
        6: begin
          apply_setting(4, 8, 1000, 60, 5);
          gen_random_samples(280);
        end
        default: begin
          apply_setting(8, 8, 50, 36, 1);
          gen_random_samples(300);
        end
      endcase
      drain_and_settle();
    end

    if (n_errors == 0) begin
      $display("** key_matrix_debounce_to_notes: PASSED **");
    end else begin
      $display("** key_matrix_debounce_to_notes: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("TIMEOUT waiting for the block");
    $display("** key_matrix_debounce_to_notes: FAILED **");
    $finish;
  end

endmodule
